### design/gbw_pkg.sv
`timescale 1ns / 1ps
package gbw_pkg;

	localparam int PIX_W      = 8;
	localparam int WIN_SIDE   = 5;
	localparam int WIN_TAPS   = WIN_SIDE * WIN_SIDE;
	localparam int FILL_W     = 5;
	localparam int IW_W       = 13;
	localparam logic [IW_W-1:0] IW_RESET = 13'd256;

	// Grey value: floor(s / 3) == (s * 683) >> 11 for every s up to 765.
	localparam int SUM3_W     = 10;
	localparam int GREY_PROD_W = 20;
	localparam int GREY_RECIP = 683;
	localparam int GREY_SHIFT = 11;

	// Kernel sum division: floor(acc / 273) == (acc * 245823) >> 26 for acc up to 69615.
	localparam int ROW_W      = 15;
	localparam int ACC_W      = 17;
	localparam int DIV_RECIP_W = 18;
	localparam int DIV_PROD_W = ACC_W + DIV_RECIP_W;
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 18'd245823;
	localparam int DIV_SHIFT  = 26;

	localparam int WEIGHT_W   = 6;
	localparam logic [WEIGHT_W-1:0] GAUSS [WIN_TAPS] = '{
		6'd1,  6'd4,  6'd7,  6'd4,  6'd1,
		6'd4,  6'd16, 6'd26, 6'd16, 6'd4,
		6'd7,  6'd26, 6'd41, 6'd26, 6'd7,
		6'd4,  6'd16, 6'd26, 6'd16, 6'd4,
		6'd1,  6'd4,  6'd7,  6'd4,  6'd1
	};

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;
	localparam int REG_IDX_W   = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;

	typedef logic [WIN_TAPS-1:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic valid;
		win_t win;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### design/gbw_front.sv
`timescale 1ns / 1ps
module gbw_front import gbw_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [PIX_W-1:0] red,
	input  logic [PIX_W-1:0] green,
	input  logic [PIX_W-1:0] blue,
	input  logic [IW_W-1:0]  image_width,
	input  q_stat_t          q_stat,
	output push_t            push
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int WW = (EW > IW_W) ? EW : IW_W;
	localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

	win_t                   win_q;
	logic [FILL_W-1:0]      fill_q;
	logic [CW-1:0]          col_q;

	win_t                   win_n;
	logic [SUM3_W-1:0]      sum3;
	logic [GREY_PROD_W-1:0] grey_prod;
	logic [PIX_W-1:0]       grey;
	logic                   col_zero;
	logic [FILL_W-1:0]      load_idx;
	logic [FILL_W-1:0]      row_idx;
	logic [FILL_W-1:0]      fill_inc;
	logic                   done;
	logic [WW-1:0]          eff_width;
	logic [WW-1:0]          col_inc;
	logic                   wrap;
	logic                   accept;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;

	always_comb begin
		sum3      = SUM3_W'(red) + SUM3_W'(green) + SUM3_W'(blue);
		grey_prod = GREY_PROD_W'(sum3) * GREY_PROD_W'(GREY_RECIP);
		grey      = grey_prod[GREY_SHIFT+PIX_W-1:GREY_SHIFT];
		col_zero  = (col_q == '0);
		load_idx  = (fill_q >= FILL_W'(WIN_TAPS)) ? '0 : fill_q;
		row_idx   = (fill_q >= FILL_W'(WIN_SIDE)) ? '0 : fill_q;

		// At column zero one tap is loaded; otherwise one row shifts left.
		win_n = win_q;
		for (int r = 0; r < WIN_SIDE; r++) begin
			if (col_zero) begin
				for (int c = 0; c < WIN_SIDE; c++) begin
					if (load_idx == FILL_W'(r * WIN_SIDE + c)) begin
						win_n[r * WIN_SIDE + c] = grey;
					end
				end
			end else if (row_idx == FILL_W'(r)) begin
				for (int c = 0; c < WIN_SIDE - 1; c++) begin
					win_n[r * WIN_SIDE + c] = win_q[r * WIN_SIDE + c + 1];
				end
				win_n[r * WIN_SIDE + WIN_SIDE - 1] = grey;
			end
		end

		fill_inc = (col_zero ? load_idx : row_idx) + FILL_W'(1);
		done     = col_zero ? (fill_inc == FILL_W'(WIN_TAPS)) : (fill_inc == FILL_W'(WIN_SIDE));

		if (image_width == '0) begin
			eff_width = WW'(1);
		end else if (WW'(image_width) > MAX_W) begin
			eff_width = MAX_W;
		end else begin
			eff_width = WW'(image_width);
		end
		col_inc = WW'(col_q) + WW'(1);
		wrap    = (col_inc >= eff_width);
	end

	assign push.valid = accept && done;
	assign push.win   = win_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			col_q  <= '0;
		end else if (accept) begin
			if (done) begin
				fill_q <= '0;
				col_q  <= wrap ? '0 : col_inc[CW-1:0];
			end else begin
				fill_q <= fill_inc;
			end
		end
	end

	// Every tap is written before a window completes, so the window needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= win_n;
		end
	end

endmodule

### design/gbw_queue.sv
`timescale 1ns / 1ps
module gbw_queue import gbw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop_ready,
	output logic    pop_valid,
	output win_t    pop_win,
	output q_stat_t q_stat
);

	win_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_valid    = !q_stat.empty;
	assign pop_win      = mem_q[rd_ptr_q];
	assign do_push      = push.valid && !q_stat.full;
	assign do_pop       = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.win;
		end
	end

endmodule

### design/gbw_back.sv
`timescale 1ns / 1ps
module gbw_back import gbw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	input  win_t             pop_win,
	output logic             pop_ready,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PIX_W-1:0] blurred
);

	logic [ROW_W-1:0]      rows_s1 [WIN_SIDE];
	logic                  v_s1;
	logic [ACC_W-1:0]      acc_s2;
	logic                  v_s2;
	logic [PIX_W-1:0]      blurred_s3;
	logic                  v_s3;

	logic [ROW_W-1:0]      row_sum [WIN_SIDE];
	logic [ACC_W-1:0]      acc_sum;
	logic [DIV_PROD_W-1:0] div_prod;
	logic                  en1;
	logic                  en2;
	logic                  en3;

	assign en3       = !v_s3 || !out_stall;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign pop_ready = en1;
	assign out_valid = v_s3;
	assign blurred   = blurred_s3;

	always_comb begin
		for (int r = 0; r < WIN_SIDE; r++) begin
			row_sum[r] = '0;
			for (int c = 0; c < WIN_SIDE; c++) begin
				row_sum[r] = row_sum[r] + ROW_W'(pop_win[r * WIN_SIDE + c])
					* ROW_W'(GAUSS[r * WIN_SIDE + c]);
			end
		end
		acc_sum = '0;
		for (int r = 0; r < WIN_SIDE; r++) begin
			acc_sum = acc_sum + ACC_W'(rows_s1[r]);
		end
		div_prod = DIV_PROD_W'(acc_s2) * DIV_PROD_W'(DIV_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= pop_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && pop_valid) begin
			rows_s1 <= row_sum;
		end
		if (en2 && v_s1) begin
			acc_s2 <= acc_sum;
		end
		if (en3 && v_s2) begin
			blurred_s3 <= div_prod[DIV_SHIFT+PIX_W-1:DIV_SHIFT];
		end
	end

endmodule

### design/gaussian_blur_5x5_window.sv
// Path: a completed window waits in the window queue; its result is offered from stage s3.
// Throughput: one pixel per cycle while in_stall is low; one result per 25 pixels at the
// first column of a row and per 5 pixels at every later column. A two-entry window queue
// decouples the pixel front end from the three-stage weighted sum and divide pipeline.
// Reset: arst_n clears all control state and sets image_width to 256; window taps are
// overwritten before use and are not cleared.
`timescale 1ns / 1ps
module gaussian_blur_5x5_window import gbw_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      red,
	input  logic [PIX_W-1:0]      green,
	input  logic [PIX_W-1:0]      blue,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      blurred,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [IW_W-1:0] image_width_q;
	push_t           push;
	q_stat_t         q_stat;
	logic            pop_valid;
	logic            pop_ready;
	win_t            pop_win;
	logic            reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_IMAGE_WIDTH);

	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata = APB_DATA_W'(image_width_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IW_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			image_width_q <= pwdata[IW_W-1:0];
		end
	end

	gbw_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.image_width(image_width_q),
		.q_stat     (q_stat),
		.push       (push)
	);

	gbw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop_ready(pop_ready),
		.pop_valid(pop_valid),
		.pop_win  (pop_win),
		.q_stat   (q_stat)
	);

	gbw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_win  (pop_win),
		.pop_ready(pop_ready),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.blurred  (blurred)
	);

`ifndef SYNTH
	// A completed window must never be offered to a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) push.valid |-> !q_stat.full)
		else $error("window pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) !(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty at once");

	// With no request leaving the queue, a full queue stays full.
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.full && !(pop_valid && pop_ready)) |=> q_stat.full)
		else $error("queue lost an entry without a pop");
`endif

endmodule

### bench/gaussian_blur_5x5_window_tb.sv
`timescale 1ns / 1ps
module gaussian_blur_5x5_window_tb;
	import gbw_pkg::*;

	localparam int WIDTH_CAP     = 4096;
	localparam int KERNEL_SUM    = 273;
	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_PIXELS = 300;
	localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR = {REG_IMAGE_WIDTH, 2'b00};
	localparam int unsigned BLUR_KERNEL [WIN_TAPS] = '{
		1,  4,  7,  4, 1,
		4, 16, 26, 16, 4,
		7, 26, 41, 26, 7,
		4, 16, 26, 16, 4,
		1,  4,  7,  4, 1
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [PIX_W-1:0]      red = '0;
	logic [PIX_W-1:0]      green = '0;
	logic [PIX_W-1:0]      blue = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [PIX_W-1:0]      blurred;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Shadow of the block: grey window, fill position, column and width register.
	logic [PIX_W-1:0] grey_win [WIN_TAPS];
	int unsigned      fill_pos;
	int unsigned      win_column;
	logic [IW_W-1:0]  width_reg;

	logic [PIX_W-1:0] blurred_q [$];
	int unsigned      errors = 0;
	int unsigned      cycles = 0;
	bit               steady = 1'b0;

	gaussian_blur_5x5_window #(.MAX_WIDTH(WIDTH_CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.red(red), .green(green), .blue(blue),
		.out_valid(out_valid), .out_stall(out_stall), .blurred(blurred),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void note_failure(input string what, input int unsigned want,
			input int unsigned got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
	endfunction

	function automatic void predict_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b);
		int unsigned grey;
		int unsigned base;
		int unsigned acc;
		int unsigned eff;
		bit complete;
		grey = (int'(r) + int'(g) + int'(b)) / 3;
		if (win_column == 0) begin
			if (fill_pos >= WIN_TAPS)
				fill_pos = 0;
			grey_win[fill_pos] = grey[PIX_W-1:0];
			fill_pos++;
			complete = (fill_pos == WIN_TAPS);
		end else begin
			// Each arriving pixel feeds one window row in turn, shifting it left.
			if (fill_pos >= WIN_SIDE)
				fill_pos = 0;
			base = fill_pos * WIN_SIDE;
			for (int u = 0; u < WIN_SIDE - 1; u++)
				grey_win[base + u] = grey_win[base + u + 1];
			grey_win[base + WIN_SIDE - 1] = grey[PIX_W-1:0];
			fill_pos++;
			complete = (fill_pos == WIN_SIDE);
		end
		if (complete) begin
			acc = 0;
			for (int i = 0; i < WIN_TAPS; i++)
				acc += grey_win[i] * BLUR_KERNEL[i];
			blurred_q.push_back(PIX_W'(acc / KERNEL_SUM));
			fill_pos = 0;
			eff = (width_reg == 0) ? 1 : ((width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg);
			if (win_column + 1 >= eff)
				win_column = 0;
			else
				win_column++;
		end
	endfunction

	function automatic logic [PIX_W-1:0] rand_channel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Holds in_valid across back-to-back requests; a gap lowers it first.
	task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b);
		if (!steady) begin
			while ($urandom_range(0, 99) < 35) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (in_stall);
		predict_pixel(r, g, b);
	endtask

	task automatic send_random(input int unsigned count);
		for (int unsigned k = 0; k < count; k++)
			send_pixel(rand_channel(), rand_channel(), rand_channel());
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (blurred_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic read_width();
		logic [APB_DATA_W-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= WIDTH_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got[IW_W-1:0] !== width_reg)
			note_failure("image_width readback", width_reg, got[IW_W-1:0]);
	endtask

	// Upper data bits carry noise; only the low 13 bits belong to the register.
	task automatic write_width(input logic [IW_W-1:0] value);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WIDTH_ADDR;
		pwdata <= {(APB_DATA_W - IW_W)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		width_reg = value;
		@(posedge clk);
		read_width();
	endtask

	task automatic test_reset_width();
		read_width();
	endtask

	task automatic test_extreme_pixels();
		for (int k = 0; k < WIN_TAPS; k++)
			send_pixel('1, '1, '1);
		for (int k = 0; k < WIN_SIDE; k++)
			send_pixel('0, '0, '0);
		for (int k = 0; k < WIN_SIDE; k++)
			send_pixel(k[0] ? 8'hFF : 8'h00, k[1] ? 8'hAA : 8'h55, k[2] ? 8'hFF : 8'h01);
	endtask

	task automatic test_narrow_widths();
		write_width('0);
		send_random(WIN_SIDE + 2 * WIN_TAPS);
		write_width(13'd1);
		send_random(WIN_TAPS);
	endtask

	task automatic test_width_change_mid_row();
		write_width(13'd8);
		send_random(2 * WIN_TAPS);
		// The row is now past the new width and must wrap after its current window.
		write_width(13'd3);
		send_random(WIN_SIDE + WIN_TAPS + WIN_SIDE);
		write_width(13'd20);
		send_random(2 * WIN_SIDE);
	endtask

	task automatic test_width_clamp();
		write_width('1);
		steady = 1'b1;
		send_random(WIN_TAPS + 4 * WIN_SIDE);
		steady = 1'b0;
		write_width(13'(WIDTH_CAP));
		send_random(WIN_TAPS + 2 * WIN_SIDE);
	endtask

	task automatic test_random_stream();
		int unsigned sent;
		int unsigned phase;
		int unsigned count;
		logic [IW_W-1:0] w;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			case ($urandom_range(0, 9))
				0: w = '0;
				1: w = 13'd1;
				8: w = 13'($urandom_range(0, 8191));
				9: w = 13'(WIDTH_CAP);
				default: w = 13'($urandom_range(2, 6));
			endcase
			write_width(w);
			steady = (phase >= 3 && phase <= 5);
			count = $urandom_range(20, 90);
			send_random(count);
			sent += count;
			phase++;
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 35);
	end

	always @(posedge clk) begin : check_results
		logic [PIX_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (blurred_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result %0d with no request pending", $realtime, blurred);
			end else begin
				want = blurred_q.pop_front();
				if (blurred !== want)
					note_failure("blurred", want, blurred);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < WIN_TAPS; i++)
			grey_win[i] = '0;
		fill_pos = 0;
		win_column = 0;
		width_reg = IW_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_width();
		test_extreme_pixels();
		test_narrow_widths();
		test_width_change_mid_row();
		test_width_clamp();
		test_random_stream();

		wait_drained();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
